// ===== hw/rtl/rteq_pkg.sv =====
// ----------------------------------------------------------------------------
// rteq_pkg
// Types and constants shared by the recurring timer event queue files.
// ----------------------------------------------------------------------------
package rteq_pkg;

  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_DEL  = 2'd1;
  localparam logic [1:0] FUNC_FIRE = 2'd2;

  localparam logic [31:0] DAY_SECONDS  = 32'd86400;
  localparam logic [31:0] WEEK_SECONDS = 32'd604800;
  localparam logic [3:0]  WEEK_DAYS    = 4'd7;
  localparam logic [3:0]  DAILY_CODE   = 4'd8;

  // Reciprocals for exact division by multiplication. A day is 675 << 7
  // seconds, so n / 86400 is (n >> 7) * DAY_RECIP >> 35 for any 32-bit n.
  // A day number below 2^16 divided by seven is d * SEVEN_RECIP >> 19.
  localparam logic [25:0] DAY_RECIP   = 26'd50903317;
  localparam logic [16:0] SEVEN_RECIP = 17'd74899;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_seconds;
    logic [31:0] task_time;
    logic [3:0]  task_weekday;
    logic [3:0]  task_operation;
    logic        task_on;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  fired_operation;
    logic        fired_on;
    logic        head_valid;
    logic [31:0] head_time;
    logic [4:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] due_time;
    logic [3:0]  repeat_day;
    logic [3:0]  action_code;
    logic        action_level;
  } entry_t;

endpackage

// ===== hw/rtl/recurring_timer_event_queue_core.sv =====
// ----------------------------------------------------------------------------
// recurring_timer_event_queue_core
// Pool of timed entries kept as a due-time ordered linked list in RAM.
//
// Usage: a request item on req (valid/ready) carries an add, a delete by due
// time or a fire of the head entry. Each request gives exactly one response
// item on rsp (valid/ready) with the status, the fired action and the list
// head time and length afterwards. One request is worked on at a time; req
// is ready only while the engine is idle.
// Steps: an add scans the busy bits one slot a cycle for a free slot, a weekly
// add or fire divides by 86400 through reciprocal multiplies and then forms
// the target time, every list node visited by an insert or delete is read
// from RAM before it is compared, and linking plus the head read for the
// response come last. req ready rises with rsp valid, at the same edge.
// Reset empties the list at once (busy bits cleared, head null), so no
// clearing pass is needed. If the receiver stalls, the finished response
// waits in the output register and the engine holds before its last step.
// ----------------------------------------------------------------------------
module recurring_timer_event_queue_core #(
  parameter int SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rteq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rteq_pkg::rsp_t rsp
);
  import rteq_pkg::*;

  // Link width holds a slot number or the null marker (SLOTS).
  localparam int LW = $clog2(SLOTS + 1);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_SCAN  = 16'h0002,
    S_DIV   = 16'h0004,
    S_WCALC = 16'h0008,
    S_INS   = 16'h0010,
    S_IRD   = 16'h0020,
    S_ICMP  = 16'h0040,
    S_LINKA = 16'h0080,
    S_LINKB = 16'h0100,
    S_DRD   = 16'h0200,
    S_DCMP  = 16'h0400,
    S_FRD   = 16'h0800,
    S_FPOP  = 16'h1000,
    S_HSET  = 16'h2000,
    S_HRD   = 16'h4000,
    S_HCAP  = 16'h8000
  } state_t;

  state_t state;

  // Request fields held for the whole operation.
  logic [31:0] now_s;
  logic [31:0] key_time;
  logic [3:0]  ent_wd;
  logic [3:0]  ent_op;
  logic        ent_on;

  logic [LW-1:0] head;
  logic [LW-1:0] cnt;
  logic [SLOTS-1:0] busy;

  logic [IW-1:0] scan;
  logic [LW-1:0] slot;
  logic [LW-1:0] ptr;
  logic [LW-1:0] prev;
  logic [LW-1:0] nxt;
  logic          first;
  logic [31:0]   tnew;
  logic          ok;
  logic [3:0]    f_op;
  logic          f_on;

  // Divide by one day in three steps: day numbers of now and of the entry
  // time, then both remainders and the day number of now divided by seven,
  // then that day number reduced mod 7.
  logic [31:0] dn;
  logic [31:0] dt;
  logic [15:0] qn;
  logic [15:0] qt;
  logic [13:0] qd;
  logic [16:0] rn;
  logic [16:0] rt;
  logic [2:0]  q7;
  logic [1:0]  dcnt;

  // RAM ports.
  entry_t        ent_rd;
  logic          ent_we;
  entry_t        ent_wr;
  logic [LW-1:0] lk_rd;
  logic          lk_we;
  logic [LW-1:0] lk_waddr;
  logic [LW-1:0] lk_wdata;

  rteq_ram #(.WIDTH($bits(entry_t)), .DEPTH(SLOTS)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (slot[IW-1:0]),
    .wdata (ent_wr),
    .raddr (ptr[IW-1:0]),
    .rdata (ent_rd)
  );

  rteq_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr[IW-1:0]),
    .wdata (lk_wdata),
    .raddr (ptr[IW-1:0]),
    .rdata (lk_rd)
  );

  // Reciprocal products for the divide steps.
  logic [50:0] qn_prod;
  logic [50:0] qt_prod;
  logic [32:0] qd_prod;

  assign qn_prod = dn[31:7] * DAY_RECIP;
  assign qt_prod = dt[31:7] * DAY_RECIP;
  assign qd_prod = qn * SEVEN_RECIP;

  // Weekly target from the divide results.
  logic [3:0]  today;
  logic [3:0]  ahead;
  logic [31:0] week_time;

  always_comb begin
    today = {1'b0, q7} + 4'd3;
    if (today >= WEEK_DAYS) begin
      today = today - WEEK_DAYS;
    end
    today = today + 4'd1;
    if (ent_wd > today) begin
      ahead = ent_wd - today;
    end else if (ent_wd == today && rt > rn) begin
      ahead = 4'd0;
    end else begin
      ahead = ent_wd + WEEK_DAYS - today;
    end
    week_time = now_s - 32'(rn) + 32'(ahead) * DAY_SECONDS + 32'(rt);
  end

  logic weekly_in;
  logic weekly_rd;
  logic ins_stop;

  assign weekly_in = (ent_wd >= 4'd1) && (ent_wd <= WEEK_DAYS);
  assign weekly_rd = (ent_rd.repeat_day >= 4'd1) && (ent_rd.repeat_day <= WEEK_DAYS);
  assign ins_stop  = first ? (tnew <= ent_rd.due_time) : (tnew < ent_rd.due_time);

  // RAM write controls.
  always_comb begin
    ent_we   = (state == S_INS);
    ent_wr   = '{due_time: tnew, repeat_day: ent_wd, action_code: ent_op,
                 action_level: ent_on};
    lk_we    = 1'b0;
    lk_waddr = slot;
    lk_wdata = NIL;
    case (state)
      S_INS: begin
        lk_we = (head == NIL);
      end
      S_ICMP: begin
        lk_we    = ins_stop && first;
        lk_wdata = ptr;
      end
      S_LINKA: begin
        lk_we    = 1'b1;
        lk_wdata = nxt;
      end
      S_LINKB: begin
        lk_we    = 1'b1;
        lk_waddr = prev;
        lk_wdata = slot;
      end
      S_DCMP: begin
        lk_we    = (ent_rd.due_time == key_time) && (prev != NIL);
        lk_waddr = prev;
        lk_wdata = lk_rd;
      end
      default: begin
        lk_we = 1'b0;
      end
    endcase
  end

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NIL;
      cnt       <= '0;
      busy      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // A response taken while a new one is loaded is replaced in S_HCAP.
      if (rsp_valid && rsp_ready && state != S_HCAP) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            now_s    <= req.now_seconds;
            key_time <= req.task_time;
            ent_wd   <= req.task_weekday;
            ent_op   <= req.task_operation;
            ent_on   <= req.task_on;
            ok       <= 1'b0;
            f_op     <= '0;
            f_on     <= 1'b0;
            first    <= 1'b1;
            prev     <= NIL;
            scan     <= '0;
            case (req.func)
              FUNC_ADD: begin
                state <= S_SCAN;
              end
              FUNC_DEL: begin
                ptr   <= head;
                state <= (head == NIL) ? S_HSET : S_DRD;
              end
              FUNC_FIRE: begin
                ptr   <= head;
                slot  <= head;
                state <= (head == NIL) ? S_HSET : S_FRD;
              end
              default: begin
                state <= S_HSET;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!busy[scan]) begin
            slot       <= LW'(scan);
            busy[scan] <= 1'b1;
            tnew       <= key_time;
            dn         <= now_s;
            dt         <= key_time;
            dcnt       <= '0;
            state      <= weekly_in ? S_DIV : S_INS;
          end else if (scan == IW'(SLOTS - 1)) begin
            state <= S_HSET;
          end else begin
            scan <= scan + IW'(1);
          end
        end
        S_DIV: begin
          dcnt <= dcnt + 2'd1;
          if (dcnt == 2'd0) begin
            qn <= qn_prod[50:35];
            qt <= qt_prod[50:35];
          end else if (dcnt == 2'd1) begin
            rn <= 17'(dn - 32'(qn) * DAY_SECONDS);
            rt <= 17'(dt - 32'(qt) * DAY_SECONDS);
            qd <= qd_prod[32:19];
          end else begin
            q7    <= 3'(qn - 16'(qd) * 16'd7);
            state <= S_WCALC;
          end
        end
        S_WCALC: begin
          tnew  <= week_time;
          state <= S_INS;
        end
        S_INS: begin
          cnt <= cnt + LW'(1);
          ok  <= 1'b1;
          if (head == NIL) begin
            head  <= slot;
            state <= S_HSET;
          end else begin
            ptr   <= head;
            first <= 1'b1;
            state <= S_IRD;
          end
        end
        S_IRD: begin
          state <= S_ICMP;
        end
        S_ICMP: begin
          if (ins_stop) begin
            if (first) begin
              head  <= slot;
              state <= S_HSET;
            end else begin
              nxt   <= ptr;
              state <= S_LINKA;
            end
          end else begin
            prev  <= ptr;
            first <= 1'b0;
            if (lk_rd == NIL) begin
              nxt   <= NIL;
              state <= S_LINKA;
            end else begin
              ptr   <= lk_rd;
              state <= S_IRD;
            end
          end
        end
        S_LINKA: begin
          state <= S_LINKB;
        end
        S_LINKB: begin
          state <= S_HSET;
        end
        S_DRD: begin
          state <= S_DCMP;
        end
        S_DCMP: begin
          if (ent_rd.due_time == key_time) begin
            if (prev == NIL) begin
              head <= lk_rd;
            end
            busy[ptr[IW-1:0]] <= 1'b0;
            cnt   <= cnt - LW'(1);
            ok    <= 1'b1;
            state <= S_HSET;
          end else begin
            prev <= ptr;
            if (lk_rd == NIL) begin
              state <= S_HSET;
            end else begin
              ptr   <= lk_rd;
              state <= S_DRD;
            end
          end
        end
        S_FRD: begin
          state <= S_FPOP;
        end
        S_FPOP: begin
          f_op   <= ent_rd.action_code;
          f_on   <= ent_rd.action_level;
          ent_wd <= ent_rd.repeat_day;
          ent_op <= ent_rd.action_code;
          ent_on <= ent_rd.action_level;
          head   <= lk_rd;
          cnt    <= cnt - LW'(1);
          ok     <= 1'b1;
          tnew   <= ent_rd.due_time + DAY_SECONDS;
          dn     <= now_s;
          dt     <= ent_rd.due_time + WEEK_SECONDS;
          dcnt   <= '0;
          if (ent_rd.repeat_day == DAILY_CODE) begin
            state <= S_INS;
          end else if (weekly_rd) begin
            state <= S_DIV;
          end else begin
            busy[slot[IW-1:0]] <= 1'b0;
            state <= S_HSET;
          end
        end
        S_HSET: begin
          ptr   <= head;
          state <= S_HRD;
        end
        S_HRD: begin
          state <= S_HCAP;
        end
        S_HCAP: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid           <= 1'b1;
            rsp.ok              <= ok;
            rsp.fired_operation <= f_op;
            rsp.fired_on        <= f_on;
            rsp.head_valid      <= (head != NIL);
            rsp.head_time       <= (head != NIL) ? ent_rd.due_time : 32'd0;
            rsp.entry_count     <= 5'(cnt);
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/rteq_ram.sv =====
// ----------------------------------------------------------------------------
// rteq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rteq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rteq_checker.sv =====
// ----------------------------------------------------------------------------
// rteq_port_checks
// Port-level checks for the recurring timer event queue, bound to the core.
// ----------------------------------------------------------------------------
module rteq_port_checks (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input rteq_pkg::rsp_t rsp
);
  import rteq_pkg::*;

  // An empty list reports no entries and a zero head time.
  a_empty_list: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.head_valid |-> rsp.entry_count == 5'd0 && rsp.head_time == 32'd0)
    else $error("empty list with nonzero count or head time");

  // A failed operation reports no fired action.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.fired_operation == 4'd0 && !rsp.fired_on)
    else $error("failed operation reports a fired action");

  // One request at a time: after an accept the engine is busy.
  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted back to back");

  // No response right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // A held response keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

endmodule

bind recurring_timer_event_queue_core rteq_port_checks u_rteq_port_checks (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ===== sim/rteq_checker.sv =====
// ----------------------------------------------------------------------------
// rteq_checker
// Watches both channels of the timer queue, keeps its own copy of the slot
// pool and list, and compares every response item with the expected one.
// ----------------------------------------------------------------------------
module rteq_checker
  import rteq_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   req_valid,
  input  logic   req_ready,
  input  req_t   req,
  input  logic   rsp_valid,
  input  logic   rsp_ready,
  input  rsp_t   rsp,
  output int     errors,
  output int     pending,
  output int     checked
);

  localparam int NIL = SLOTS;

  entry_t pool_q[SLOTS];
  logic   busy_q[SLOTS];
  int     link_q[SLOTS];
  int     head_q;
  int     count_q;
  rsp_t   expected_rsps[$];

  function automatic logic [31:0] next_weekday_time(logic [31:0] t, logic [3:0] wd,
                                                    logic [31:0] now);
    logic [31:0] tod;
    logic [31:0] today;
    logic [31:0] ahead;
    tod   = now % DAY_SECONDS;
    today = ((now / DAY_SECONDS) + 32'd3) % 32'(WEEK_DAYS) + 32'd1;
    if (32'(wd) > today) begin
      ahead = 32'(wd) - today;
    end else if (32'(wd) == today && (t % DAY_SECONDS) > tod) begin
      ahead = 32'd0;
    end else begin
      ahead = 32'(wd) + 32'(WEEK_DAYS) - today;
    end
    return (now - tod) + ahead * DAY_SECONDS + (t % DAY_SECONDS);
  endfunction

  function automatic bit is_weekly(logic [3:0] wd);
    return wd >= 4'd1 && wd <= WEEK_DAYS;
  endfunction

  // Ordered insert: ahead of the head when not later, else after all entries
  // that are equal or earlier.
  task automatic link_in(int s);
    int prev;
    int nx;
    count_q++;
    if (head_q == NIL) begin
      link_q[s] = NIL;
      head_q = s;
    end else if (pool_q[s].due_time <= pool_q[head_q].due_time) begin
      link_q[s] = head_q;
      head_q = s;
    end else begin
      prev = head_q;
      for (int i = 0; i < SLOTS; i++) begin
        nx = link_q[prev];
        if (nx == NIL || pool_q[s].due_time < pool_q[nx].due_time) break;
        prev = nx;
      end
      link_q[s] = link_q[prev];
      link_q[prev] = s;
    end
  endtask

  task automatic predict_rsp(req_t r);
    rsp_t e;
    int   s;
    int   prev;
    int   cur;
    e = '0;
    case (r.func)
      FUNC_ADD: begin
        s = NIL;
        for (int i = SLOTS - 1; i >= 0; i--) if (!busy_q[i]) s = i;
        if (s != NIL) begin
          busy_q[s] = 1'b1;
          pool_q[s].due_time = is_weekly(r.task_weekday) ?
              next_weekday_time(r.task_time, r.task_weekday, r.now_seconds) : r.task_time;
          pool_q[s].repeat_day   = r.task_weekday;
          pool_q[s].action_code  = r.task_operation;
          pool_q[s].action_level = r.task_on;
          link_in(s);
          e.ok = 1'b1;
        end
      end
      FUNC_DEL: begin
        prev = NIL;
        cur  = head_q;
        while (cur != NIL) begin
          if (pool_q[cur].due_time == r.task_time) begin
            if (prev == NIL) head_q = link_q[cur];
            else link_q[prev] = link_q[cur];
            busy_q[cur] = 1'b0;
            count_q--;
            e.ok = 1'b1;
            break;
          end
          prev = cur;
          cur  = link_q[cur];
        end
      end
      FUNC_FIRE: begin
        if (head_q != NIL) begin
          s = head_q;
          e.ok = 1'b1;
          e.fired_operation = pool_q[s].action_code;
          e.fired_on        = pool_q[s].action_level;
          head_q = link_q[s];
          count_q--;
          if (pool_q[s].repeat_day == DAILY_CODE) begin
            pool_q[s].due_time = pool_q[s].due_time + DAY_SECONDS;
            link_in(s);
          end else if (is_weekly(pool_q[s].repeat_day)) begin
            pool_q[s].due_time = next_weekday_time(pool_q[s].due_time + WEEK_SECONDS,
                                                   pool_q[s].repeat_day, r.now_seconds);
            link_in(s);
          end else begin
            busy_q[s] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    e.head_valid  = (head_q != NIL);
    e.head_time   = (head_q != NIL) ? pool_q[head_q].due_time : 32'd0;
    e.entry_count = 5'(count_q);
    expected_rsps.push_back(e);
  endtask

  task automatic compare_rsp(rsp_t a);
    rsp_t e;
    if (expected_rsps.size() == 0) begin
      $error("response item with nothing expected");
      errors++;
      return;
    end
    e = expected_rsps.pop_front();
    checked++;
    if (a.ok !== e.ok) begin
      $error("ok: expected %0d actual %0d", e.ok, a.ok); errors++;
    end
    if (a.fired_operation !== e.fired_operation) begin
      $error("fired_operation: expected %0d actual %0d", e.fired_operation,
             a.fired_operation); errors++;
    end
    if (a.fired_on !== e.fired_on) begin
      $error("fired_on: expected %0d actual %0d", e.fired_on, a.fired_on); errors++;
    end
    if (a.head_valid !== e.head_valid) begin
      $error("head_valid: expected %0d actual %0d", e.head_valid, a.head_valid); errors++;
    end
    if (a.head_time !== e.head_time) begin
      $error("head_time: expected %0h actual %0h", e.head_time, a.head_time); errors++;
    end
    if (a.entry_count !== e.entry_count) begin
      $error("entry_count: expected %0d actual %0d", e.entry_count, a.entry_count);
      errors++;
    end
  endtask

  initial begin
    errors  = 0;
    checked = 0;
    head_q  = NIL;
    count_q = 0;
    for (int i = 0; i < SLOTS; i++) begin
      busy_q[i] = 1'b0;
      link_q[i] = NIL;
      pool_q[i] = '0;
    end
  end

  assign pending = expected_rsps.size();

  // The response is compared before the new request is predicted, since a
  // response accepted at this edge always belongs to an earlier request.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) compare_rsp(rsp);
      if (req_valid && req_ready) predict_rsp(req);
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the timer queue with directed and random request items, stalls the
// response side at random and once for a long stretch, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import rteq_pkg::*;

  localparam int SLOTS       = 16;
  localparam int RANDOM_ITEMS = 1300;
  localparam int IDLE_LIMIT  = 20000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  int   errors;
  int   pending;
  int   checked;
  int   idle_cycles;
  int   sent_by_func[4];
  bit   long_stall_done;

  recurring_timer_event_queue_core #(.SLOTS(SLOTS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  rteq_checker #(.SLOTS(SLOTS)) i_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Sends one item. Valid goes low only when a gap is taken, so a back to back
  // item never sees valid dropped and raised in the same time step.
  task automatic send_item(req_t r);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = r;
    req_valid = 1'b1;
    sent_by_func[r.func]++;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic req_t make_item(logic [1:0] f, logic [31:0] t, logic [3:0] wd,
                                     logic [31:0] now);
    req_t r;
    r.func           = f;
    r.now_seconds    = now;
    r.task_time      = t;
    r.task_weekday   = wd;
    r.task_operation = 4'($urandom_range(0, 15));
    r.task_on        = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Random item. Times come mostly from a small set so that deletes hit and
  // equal due times occur; some sit near 2^32 and the rest span the full range.
  function automatic req_t random_item();
    int   roll;
    logic [1:0]  f;
    logic [31:0] t;
    logic [31:0] now;
    logic [3:0]  wd;
    roll = $urandom_range(0, 99);
    if (roll < 45) f = FUNC_ADD;
    else if (roll < 70) f = FUNC_DEL;
    else if (roll < 96) f = FUNC_FIRE;
    else f = 2'd3;
    roll = $urandom_range(0, 99);
    if (roll < 60) t = 32'd1700000000 + 32'($urandom_range(0, 15)) * 32'd3600;
    else if (roll < 70) t = 32'hFFFF_FFFF - 32'($urandom_range(0, 200000));
    else t = $urandom;
    now = ($urandom_range(0, 1) == 0) ? 32'd1700000000 + 32'($urandom_range(0, 1209600))
                                      : $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 40) wd = 4'd0;
    else if (roll < 65) wd = 4'($urandom_range(1, 7));
    else if (roll < 80) wd = DAILY_CODE;
    else wd = 4'($urandom_range(0, 15));
    return make_item(f, t, wd, now);
  endfunction

  // Stimulus.
  initial begin
    req_t r;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty list cases and the unused function code first.
    send_item(make_item(FUNC_FIRE, 32'd0, 4'd0, 32'd0));
    send_item(make_item(FUNC_DEL, 32'd5, 4'd0, 32'd0));
    send_item(make_item(2'd3, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF));
    // Extreme times, equal times, every weekday code including the unused ones.
    send_item(make_item(FUNC_ADD, 32'hFFFF_FFFF, 4'd0, 32'd0));
    send_item(make_item(FUNC_ADD, 32'd0, 4'd0, 32'd0));
    send_item(make_item(FUNC_ADD, 32'd0, 4'd0, 32'd0));
    send_item(make_item(FUNC_ADD, 32'hFFFF_FF00, DAILY_CODE, 32'd0));
    for (int wd = 1; wd <= 15; wd++) begin
      send_item(make_item(FUNC_ADD, 32'd1700000000 + 32'(wd) * 32'd1000, 4'(wd),
                          32'hFFFF_FFFF - 32'(wd) * 32'd40000));
    end
    // The pool is now full: one more add must fail.
    send_item(make_item(FUNC_ADD, 32'd123, 4'd0, 32'd0));
    send_item(make_item(FUNC_DEL, 32'hFFFF_FFFF, 4'd0, 32'd0));
    send_item(make_item(FUNC_DEL, 32'd0, 4'd0, 32'd0));
    // Fire everything out; daily and weekly entries come back and wrap in time.
    for (int i = 0; i < 20; i++) begin
      send_item(make_item(FUNC_FIRE, 32'd0, 4'd0, $urandom));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = random_item();
      send_item(r);
    end
    req_valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("Ran %0d adds, %0d deletes, %0d fires and %0d unused codes;",
             sent_by_func[0], sent_by_func[1], sent_by_func[2], sent_by_func[3]);
    $display("%0d response items compared, including a full pool and a long stall.",
             checked);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps
  // offering items, so the block backs up and stops taking requests.
  initial begin
    int gap;
    rsp_ready = 1'b0;
    long_stall_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!long_stall_done && checked >= 600) begin
        long_stall_done = 1'b1;
        rsp_ready = 1'b0;
        repeat (400) @(negedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
      if (gap > 0) begin
        rsp_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready = 1'b1;
      @(negedge clk);
    end
  end

  // Watchdog on cycles with no item accepted on either channel.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
hw/rtl/rteq_pkg.sv
hw/rtl/rteq_ram.sv
hw/rtl/recurring_timer_event_queue_core.sv
hw/rtl/rteq_checker.sv
sim/rteq_checker.sv
sim/tb_top.sv
